[rtl/acl_pkg.sv]
package acl_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int BTN_W      = 5;
  localparam int BLINK_W    = 10;
  localparam int CODE_W     = 4;
  localparam int FAIL_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Averaging window
  localparam int AVG_DEPTH = 128;
  localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W     = SAMPLE_W + $clog2(AVG_DEPTH);

  // Keypad
  localparam int CODE_KEYS = 4;
  localparam logic [CODE_W-1:0] KEY_MASK =
    (CODE_KEYS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << CODE_KEYS) - 1);
  localparam logic [BTN_W-1:0]   NEW_ATTEMPT = 5'b11110;
  localparam logic [BLINK_W-1:0] COUNT_MAX   = {BLINK_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_BOTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_GAS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TEMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECRET     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG  = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] gas_threshold;
    logic [SAMPLE_W-1:0] over_temp_code;
    logic [BLINK_W-1:0]  blink_both_ticks;
    logic [BLINK_W-1:0]  blink_gas_ticks;
    logic [BLINK_W-1:0]  blink_temp_ticks;
    logic [CODE_W-1:0]   secret_code;
    logic [FAIL_W-1:0]   max_wrong_attempts;
  } acl_cfg_t;

  typedef struct packed {
    logic alarm_active;
    logic alarm_lamp;
    logic siren_n;
    logic incorrect_led;
    logic blocked_led;
    logic over_temp;
  } acl_res_t;

endpackage

[rtl/acl_avg.sv]
module acl_avg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [acl_pkg::SAMPLE_W-1:0] temp_i,
  input  logic [acl_pkg::SAMPLE_W-1:0] over_temp_code_i,
  output logic                         hot_o
);
  import acl_pkg::*;

  logic [SAMPLE_W-1:0] ring_mem [AVG_DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                wrapped_q, wrapped_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SUM_W-1:0]    limit;
  logic [SAMPLE_W-1:0] oldest;

  // entries not yet written since reset read as zero
  assign oldest = wrapped_q ? rd_q : '0;
  assign sum_d  = sum_q - SUM_W'(oldest) + SUM_W'(temp_i);
  assign limit  = SUM_W'(over_temp_code_i) * SUM_W'(AVG_DEPTH);
  assign hot_o  = sum_d > limit;

  always_comb begin
    idx_d     = idx_q;
    wrapped_d = wrapped_q;
    if (fire_i) begin
      if (idx_q == IDX_W'(AVG_DEPTH - 1)) begin
        idx_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  // read port prefetches the slot of the next transaction, write-first
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      ring_mem[idx_q] <= temp_i;
    end
    if (fire_i && (idx_d == idx_q)) begin
      rd_q <= temp_i;
    end else begin
      rd_q <= ring_mem[idx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      wrapped_q <= 1'b0;
      sum_q     <= '0;
    end else begin
      idx_q     <= idx_d;
      wrapped_q <= wrapped_d;
      if (fire_i) begin
        sum_q <= sum_d;
      end
    end
  end

endmodule

[rtl/acl_ctrl.sv]
module acl_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  acl_pkg::acl_cfg_t            cfg_i,
  input  logic [acl_pkg::SAMPLE_W-1:0] gas_i,
  input  logic                         test_i,
  input  logic [acl_pkg::BTN_W-1:0]    buttons_i,
  input  logic                         hot_i,
  output acl_pkg::acl_res_t            res_o
);
  import acl_pkg::*;

  logic               alarm_q, alarm_d;
  logic               gas_l_q, gas_l_d;
  logic               temp_l_q, temp_l_d;
  logic [BLINK_W-1:0] blink_q, blink_d;
  logic               led_q, led_d;
  logic               siren_q, siren_d;
  logic               wrong_q, wrong_d;
  logic               lock_q, lock_d;
  logic [FAIL_W-1:0]  fail_q, fail_d;
  logic               gas_hit;
  logic               gas_set;
  logic               temp_set;
  logic [BLINK_W-1:0] period;
  logic               code_ok;

  assign gas_hit  = gas_i > cfg_i.gas_threshold;
  assign gas_set  = gas_l_q | gas_hit | test_i;
  assign temp_set = temp_l_q | hot_i | test_i;
  assign code_ok  = (buttons_i[BTN_W-1:1] & KEY_MASK) == (cfg_i.secret_code & KEY_MASK);

  always_comb begin
    priority if (gas_set && temp_set) begin
      period = cfg_i.blink_both_ticks;
    end else if (gas_set) begin
      period = cfg_i.blink_gas_ticks;
    end else begin
      period = cfg_i.blink_temp_ticks;
    end
  end

  always_comb begin
    alarm_d  = alarm_q | gas_hit | hot_i | test_i;
    gas_l_d  = gas_set;
    temp_l_d = temp_set;
    blink_d  = blink_q;
    led_d    = led_q;
    siren_d  = siren_q;
    wrong_d  = wrong_q;
    lock_d   = lock_q;
    fail_d   = fail_q;

    if (alarm_d) begin
      if (blink_q != COUNT_MAX) begin
        blink_d = blink_q + BLINK_W'(1);
      end
      siren_d = 1'b0;
      if (blink_d >= period) begin
        blink_d = '0;
        led_d   = ~led_q;
      end
    end else begin
      led_d    = 1'b0;
      siren_d  = 1'b1;
      gas_l_d  = 1'b0;
      temp_l_d = 1'b0;
    end

    // keypad; a correct code leaves LED and siren for the next tick
    if (fail_q < cfg_i.max_wrong_attempts) begin
      if (buttons_i == NEW_ATTEMPT) begin
        wrong_d = 1'b0;
      end
      if (buttons_i[0] && !wrong_d && alarm_d) begin
        if (code_ok) begin
          alarm_d = 1'b0;
          fail_d  = '0;
        end else begin
          wrong_d = 1'b1;
          fail_d  = fail_q + FAIL_W'(1);
        end
      end
    end else begin
      lock_d = 1'b1;
    end
  end

  assign res_o.alarm_active  = alarm_d;
  assign res_o.alarm_lamp    = led_d;
  assign res_o.siren_n       = siren_d;
  assign res_o.incorrect_led = wrong_d;
  assign res_o.blocked_led   = lock_d;
  assign res_o.over_temp     = hot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q  <= 1'b0;
      gas_l_q  <= 1'b0;
      temp_l_q <= 1'b0;
      blink_q  <= '0;
      led_q    <= 1'b0;
      siren_q  <= 1'b1;
      wrong_q  <= 1'b0;
      lock_q   <= 1'b0;
      fail_q   <= '0;
    end else if (fire_i) begin
      alarm_q  <= alarm_d;
      gas_l_q  <= gas_l_d;
      temp_l_q <= temp_l_d;
      blink_q  <= blink_d;
      led_q    <= led_d;
      siren_q  <= siren_d;
      wrong_q  <= wrong_d;
      lock_q   <= lock_d;
      fail_q   <= fail_d;
    end
  end

endmodule

[rtl/alarm_controller_with_code_lockout_core.sv]
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   temp_sample, gas_sample, test_button,
//                                                code_buttons
// out       source     out_valid_o / out_stall_i alarm_active, alarm_lamp, siren_n,
//                                                incorrect_led, blocked_led, over_temp
// cfg       sink       cfg_we_i                  cfg_idx_i selects, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i lets results leave; after the
// accepting edge a transaction goes from the input register, through all tick logic,
// into the result register, which raises out_valid_o. The rate rests on the running
// sum; its ring memory prefetches the next slot's oldest sample into a read register.
// Reset clears state and loads register defaults; a wrap flag masks ring contents
// until the first full pass. A held result stalls input only when it is not taken.
module alarm_controller_with_code_lockout_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [acl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [acl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // tick input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [acl_pkg::SAMPLE_W-1:0]   temp_sample_i,
  input  logic [acl_pkg::SAMPLE_W-1:0]   gas_sample_i,
  input  logic                           test_button_i,
  input  logic [acl_pkg::BTN_W-1:0]      code_buttons_i,
  // tick result
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           alarm_active_o,
  output logic                           alarm_lamp_o,
  output logic                           siren_n_o,
  output logic                           incorrect_led_o,
  output logic                           blocked_led_o,
  output logic                           over_temp_o
);
  import acl_pkg::*;

  acl_cfg_t            cfg_q;
  logic                in_vld_q;
  logic [SAMPLE_W-1:0] temp_q;
  logic [SAMPLE_W-1:0] gas_q;
  logic                test_q;
  logic [BTN_W-1:0]    btn_q;
  logic                out_vld_q;
  acl_res_t            res_q;
  acl_res_t            res;
  logic                adv;
  logic                fire;
  logic                accept;
  logic                hot;

  // result slot free, or its transaction leaves this cycle
  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gas_threshold      <= SAMPLE_W'(2047);
      cfg_q.over_temp_code     <= SAMPLE_W'(620);
      cfg_q.blink_both_ticks   <= BLINK_W'(10);
      cfg_q.blink_gas_ticks    <= BLINK_W'(100);
      cfg_q.blink_temp_ticks   <= BLINK_W'(50);
      cfg_q.secret_code        <= CODE_W'(3);
      cfg_q.max_wrong_attempts <= FAIL_W'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAS_THR:    cfg_q.gas_threshold      <= cfg_data_i;
        CFG_TEMP_CODE:  cfg_q.over_temp_code     <= cfg_data_i;
        CFG_BLINK_BOTH: cfg_q.blink_both_ticks   <= cfg_data_i[BLINK_W-1:0];
        CFG_BLINK_GAS:  cfg_q.blink_gas_ticks    <= cfg_data_i[BLINK_W-1:0];
        CFG_BLINK_TEMP: cfg_q.blink_temp_ticks   <= cfg_data_i[BLINK_W-1:0];
        CFG_SECRET:     cfg_q.secret_code        <= cfg_data_i[CODE_W-1:0];
        CFG_MAX_WRONG:  cfg_q.max_wrong_attempts <= cfg_data_i[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      temp_q <= temp_sample_i;
      gas_q  <= gas_sample_i;
      test_q <= test_button_i;
      btn_q  <= code_buttons_i;
    end
  end

  // running average of temperature
  acl_avg u_avg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .temp_i           (temp_q),
    .over_temp_code_i (cfg_q.over_temp_code),
    .hot_o            (hot)
  );

  // alarm latch, blinker, siren and keypad lockout
  acl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cfg_i     (cfg_q),
    .gas_i     (gas_q),
    .test_i    (test_q),
    .buttons_i (btn_q),
    .hot_i     (hot),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign alarm_active_o  = res_q.alarm_active;
  assign alarm_lamp_o    = res_q.alarm_lamp;
  assign siren_n_o       = res_q.siren_n;
  assign incorrect_led_o = res_q.incorrect_led;
  assign blocked_led_o   = res_q.blocked_led;
  assign over_temp_o     = res_q.over_temp;

endmodule

[dv/alarm_tick_checker.sv]
`timescale 1ns / 1ps

module alarm_tick_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [acl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [acl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [acl_pkg::SAMPLE_W-1:0]   temp_sample_i,
  input  logic [acl_pkg::SAMPLE_W-1:0]   gas_sample_i,
  input  logic                           test_button_i,
  input  logic [acl_pkg::BTN_W-1:0]      code_buttons_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           alarm_active_i,
  input  logic                           alarm_lamp_i,
  input  logic                           siren_n_i,
  input  logic                           incorrect_led_i,
  input  logic                           blocked_led_i,
  input  logic                           over_temp_i,
  output int                             errors_o,
  output int                             pending_o
);
  import acl_pkg::*;

  acl_cfg_t            regs_q;
  logic [SAMPLE_W-1:0] temp_ring_q [AVG_DEPTH];
  logic [IDX_W-1:0]    ring_ptr_q;
  logic [SUM_W-1:0]    temp_sum_q;
  logic                alarm_q, gas_cause_q, temp_cause_q;
  logic [BLINK_W-1:0]  blink_cnt_q;
  logic                led_q, siren_q, wrong_q, locked_q;
  logic [FAIL_W-1:0]   fails_q;
  acl_res_t            expected_q [$];

  // Advance the shadow alarm by one tick and return the outputs it should show.
  function automatic acl_res_t tick_alarm(input logic [SAMPLE_W-1:0] temp,
                                          input logic [SAMPLE_W-1:0] gas,
                                          input logic test,
                                          input logic [BTN_W-1:0] btn);
    acl_res_t           res;
    logic               hot;
    logic [BLINK_W-1:0] period;
    logic [CODE_W-1:0]  keys;
    temp_sum_q = temp_sum_q - temp_ring_q[ring_ptr_q] + temp;
    temp_ring_q[ring_ptr_q] = temp;
    ring_ptr_q = (ring_ptr_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : ring_ptr_q + IDX_W'(1);
    hot = int'(temp_sum_q) > int'(regs_q.over_temp_code) * AVG_DEPTH;

    if (gas > regs_q.gas_threshold) begin
      gas_cause_q = 1'b1;
      alarm_q = 1'b1;
    end
    if (hot) begin
      temp_cause_q = 1'b1;
      alarm_q = 1'b1;
    end
    if (test) begin
      gas_cause_q = 1'b1;
      temp_cause_q = 1'b1;
      alarm_q = 1'b1;
    end
    if (alarm_q) begin
      if (blink_cnt_q != COUNT_MAX) blink_cnt_q = blink_cnt_q + BLINK_W'(1);
      siren_q = 1'b0;
      if (gas_cause_q && temp_cause_q) period = regs_q.blink_both_ticks;
      else if (gas_cause_q) period = regs_q.blink_gas_ticks;
      else period = regs_q.blink_temp_ticks;
      if (blink_cnt_q >= period) begin
        blink_cnt_q = '0;
        led_q = !led_q;
      end
    end else begin
      led_q = 1'b0;
      siren_q = 1'b1;
      gas_cause_q = 1'b0;
      temp_cause_q = 1'b0;
    end

    // keypad; entry is frozen once the failure limit is reached
    if (fails_q < regs_q.max_wrong_attempts) begin
      if (btn == NEW_ATTEMPT) wrong_q = 1'b0;
      if (btn[0] && !wrong_q && alarm_q) begin
        keys = btn[BTN_W-1:1] & KEY_MASK;
        if (keys == (regs_q.secret_code & KEY_MASK)) begin
          alarm_q = 1'b0;
          fails_q = '0;
        end else begin
          wrong_q = 1'b1;
          fails_q = fails_q + FAIL_W'(1);
        end
      end
    end else begin
      locked_q = 1'b1;
    end

    res.alarm_active  = alarm_q;
    res.alarm_lamp    = led_q;
    res.siren_n       = siren_q;
    res.incorrect_led = wrong_q;
    res.blocked_led   = locked_q;
    res.over_temp     = hot;
    return res;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0b, got %0b", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    acl_res_t want;
    if (!rst_ni) begin
      regs_q.gas_threshold      = 12'd2047;
      regs_q.over_temp_code     = 12'd620;
      regs_q.blink_both_ticks   = 10'd10;
      regs_q.blink_gas_ticks    = 10'd100;
      regs_q.blink_temp_ticks   = 10'd50;
      regs_q.secret_code        = 4'd3;
      regs_q.max_wrong_attempts = 3'd5;
      for (int i = 0; i < AVG_DEPTH; i++) temp_ring_q[i] = '0;
      ring_ptr_q   = '0;
      temp_sum_q   = '0;
      alarm_q      = 1'b0;
      gas_cause_q  = 1'b0;
      temp_cause_q = 1'b0;
      blink_cnt_q  = '0;
      led_q        = 1'b0;
      siren_q      = 1'b1;
      wrong_q      = 1'b0;
      locked_q     = 1'b0;
      fails_q      = '0;
      expected_q.delete();
      errors_o     = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GAS_THR:    regs_q.gas_threshold      = cfg_data_i[SAMPLE_W-1:0];
          CFG_TEMP_CODE:  regs_q.over_temp_code     = cfg_data_i[SAMPLE_W-1:0];
          CFG_BLINK_BOTH: regs_q.blink_both_ticks   = cfg_data_i[BLINK_W-1:0];
          CFG_BLINK_GAS:  regs_q.blink_gas_ticks    = cfg_data_i[BLINK_W-1:0];
          CFG_BLINK_TEMP: regs_q.blink_temp_ticks   = cfg_data_i[BLINK_W-1:0];
          CFG_SECRET:     regs_q.secret_code        = cfg_data_i[CODE_W-1:0];
          CFG_MAX_WRONG:  regs_q.max_wrong_attempts = cfg_data_i[FAIL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result transaction with nothing expected", $time);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("alarm_active", want.alarm_active, alarm_active_i);
          check_field("alarm_lamp", want.alarm_lamp, alarm_lamp_i);
          check_field("siren_n", want.siren_n, siren_n_i);
          check_field("incorrect_led", want.incorrect_led, incorrect_led_i);
          check_field("blocked_led", want.blocked_led, blocked_led_i);
          check_field("over_temp", want.over_temp, over_temp_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(tick_alarm(temp_sample_i, gas_sample_i, test_button_i,
                                        code_buttons_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import acl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   temp_sample_i;
  logic [SAMPLE_W-1:0]   gas_sample_i;
  logic                  test_button_i;
  logic [BTN_W-1:0]      code_buttons_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  alarm_active_o;
  logic                  alarm_lamp_o;
  logic                  siren_n_o;
  logic                  incorrect_led_o;
  logic                  blocked_led_o;
  logic                  over_temp_o;

  int errors;
  int pending;

  // Traffic shaping, changed only between phases
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_reqs     = 0;  // bumped to ask the receiver for one long hold-off

  // What the stimulus knows of the current register setting
  logic [SAMPLE_W-1:0] cur_gas_thr;
  logic [SAMPLE_W-1:0] cur_temp_code;
  logic [CODE_W-1:0]   cur_secret;
  int                  temp_base;  // center of the current temperature regime

  alarm_controller_with_code_lockout_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .temp_sample_i   (temp_sample_i),
    .gas_sample_i    (gas_sample_i),
    .test_button_i   (test_button_i),
    .code_buttons_i  (code_buttons_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .alarm_active_o  (alarm_active_o),
    .alarm_lamp_o    (alarm_lamp_o),
    .siren_n_o       (siren_n_o),
    .incorrect_led_o (incorrect_led_o),
    .blocked_led_o   (blocked_led_o),
    .over_temp_o     (over_temp_o)
  );

  alarm_tick_checker tick_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .temp_sample_i   (temp_sample_i),
    .gas_sample_i    (gas_sample_i),
    .test_button_i   (test_button_i),
    .code_buttons_i  (code_buttons_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .alarm_active_i  (alarm_active_o),
    .alarm_lamp_i    (alarm_lamp_o),
    .siren_n_i       (siren_n_o),
    .incorrect_led_i (incorrect_led_o),
    .blocked_led_i   (blocked_led_o),
    .over_temp_i     (over_temp_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side. Random stalls per cycle, plus on request one long hold-off
  // during which the sender keeps offering so the pipeline backs up.
  initial begin
    int holds_done;
    holds_done = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < snk_stall_pct);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] clip_code(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  // Offer one tick transaction, after a random number of idle cycles, and
  // return at the edge where it is taken. Valid stays up for the next call.
  task automatic send_tick(input logic [SAMPLE_W-1:0] temp,
                           input logic [SAMPLE_W-1:0] gas,
                           input logic test,
                           input logic [BTN_W-1:0] btn);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    temp_sample_i  <= temp;
    gas_sample_i   <= gas;
    test_button_i  <= test;
    code_buttons_i <= btn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Sensor values follow the current regime: temperature hovers around
  // temp_base (so the 128-tick average drifts across the limit), gas now
  // and then goes over the threshold, the test button is rare. A slice of
  // full-range noise keeps every bit moving.
  task automatic random_tick(input logic [BTN_W-1:0] btn);
    logic [SAMPLE_W-1:0] temp, gas;
    logic                test;
    if ($urandom_range(9) == 0) temp = SAMPLE_W'($urandom_range(4095));
    else temp = clip_code(temp_base + int'($urandom_range(64)) - 32);
    if ($urandom_range(99) < 8 && cur_gas_thr != '1)
      gas = SAMPLE_W'($urandom_range(4095, int'(cur_gas_thr) + 1));
    else if ($urandom_range(99) < 5)
      gas = SAMPLE_W'($urandom_range(4095));
    else
      gas = SAMPLE_W'($urandom_range(int'(cur_gas_thr)));
    test = ($urandom_range(99) < 3);
    send_tick(temp, gas, test, btn);
  endtask

  // Drop valid and wait until every expected result is back. pending is
  // registered from the checker's queue size, hence the first edge before looking at it.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
  endtask

  // Registers are only touched with the pipe empty.
  task automatic set_config(input int gas_thr, input int temp_code, input int both_p,
                            input int gas_p, input int temp_p, input int secret,
                            input int max_wrong);
    drain();
    write_reg(CFG_GAS_THR, gas_thr);
    write_reg(CFG_TEMP_CODE, temp_code);
    write_reg(CFG_BLINK_BOTH, both_p);
    write_reg(CFG_BLINK_GAS, gas_p);
    write_reg(CFG_BLINK_TEMP, temp_p);
    write_reg(CFG_SECRET, secret);
    write_reg(CFG_MAX_WRONG, max_wrong);
    cfg_we_i      <= 1'b0;
    cur_gas_thr   = SAMPLE_W'(gas_thr);
    cur_temp_code = SAMPLE_W'(temp_code);
    cur_secret    = CODE_W'(secret);
    temp_base     = temp_code;
  endtask

  // Mostly well-formed keypad use: quiet stretches, code attempts (often the
  // right code) each followed by the re-arm pattern, lone re-arms, and some
  // random button noise.
  task automatic run_random(input int n);
    int                done, kind, len;
    logic [CODE_W-1:0] keys;
    done = 0;
    while (done < n) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0, 1: temp_base = int'(cur_temp_code) + int'($urandom_range(160)) - 80;
          2:    temp_base = $urandom_range(4095);
          default: temp_base = $urandom_range(1) ? 4095 : 0;
        endcase
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        len = $urandom_range(12, 1);
        repeat (len) random_tick('0);
        done += len;
      end else if (kind < 80) begin
        keys = ($urandom_range(99) < 65) ? cur_secret : CODE_W'($urandom_range(15));
        random_tick({keys, 1'b1});
        len = $urandom_range(3);
        repeat (len) random_tick('0);
        random_tick(NEW_ATTEMPT);
        done += len + 2;
      end else if (kind < 90) begin
        random_tick(NEW_ATTEMPT);
        done++;
      end else begin
        len = $urandom_range(4, 1);
        repeat (len) random_tick(BTN_W'($urandom_range(31)));
        done += len;
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    temp_sample_i  <= '0;
    gas_sample_i   <= '0;
    test_button_i  <= 1'b0;
    code_buttons_i <= '0;
    cur_gas_thr    = 12'd2047;
    cur_temp_code  = 12'd620;
    cur_secret     = 4'd3;
    temp_base      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset register values (secret 3, limit 5).
    send_tick(12'd0, 12'd0, 1'b0, '0);
    send_tick(12'd4095, 12'd0, 1'b0, '0);              // hottest sample
    send_tick(12'd0, 12'd2047, 1'b0, '0);              // gas at threshold: no alarm
    send_tick(12'd0, 12'd2048, 1'b0, {4'd3, 1'b1});    // alarm and cleared same tick
    send_tick(12'd0, 12'd0, 1'b0, '0);                 // siren drops now; LED was never lit
    send_tick(12'd0, 12'd4095, 1'b0, '0);              // gas max
    send_tick(12'd0, 12'd0, 1'b0, {4'd0, 1'b1});       // wrong code, one failure
    send_tick(12'd0, 12'd0, 1'b0, {4'd3, 1'b1});       // ignored until re-armed
    send_tick(12'd0, 12'd0, 1'b0, NEW_ATTEMPT);
    send_tick(12'd0, 12'd0, 1'b1, '0);                 // test button
    send_tick(12'd0, 12'd0, 1'b0, {4'd15, 1'b1});      // second failure
    send_tick(12'd0, 12'd0, 1'b0, NEW_ATTEMPT);
    send_tick(12'd4095, 12'd4095, 1'b1, '1);           // all ones, third failure
    send_tick(12'd0, 12'd0, 1'b0, NEW_ATTEMPT);
    send_tick(12'd0, 12'd0, 1'b0, {4'd12, 1'b1});      // fourth
    send_tick(12'd0, 12'd0, 1'b0, NEW_ATTEMPT);
    send_tick(12'd0, 12'd0, 1'b0, {4'd8, 1'b1});       // fifth: lockout reached
    send_tick(12'd0, 12'd0, 1'b0, {4'd3, 1'b1});       // blocked LED lights, entry refused

    // Zero limit on temperature and zero blink periods; raising the failure
    // limit reopens entry while the blocked LED stays lit.
    set_config(4095, 0, 0, 0, 0, 15, 7);
    snk_stall_pct = 82;
    send_tick(12'd1, 12'd0, 1'b0, '0);                 // any nonzero sum is hot
    send_tick(12'd0, 12'd0, 1'b0, '0);                 // LED toggles every tick
    send_tick(12'd0, 12'd4095, 1'b0, '0);              // gas at max threshold: no cause
    send_tick(12'd0, 12'd0, 1'b0, {4'd15, 1'b1});      // right code, ignored until re-armed
    send_tick(12'd0, 12'd0, 1'b0, '0);

    // Random phases over several settings, extremes among them.
    set_config(2047, 620, 10, 100, 50, 3, 7);
    src_idle_pct = 0;  snk_stall_pct = 0;
    run_random(160);

    set_config($urandom_range(3500, 500), $urandom_range(900, 200), 1, 2, 3,
               $urandom_range(15), 7);
    src_idle_pct = 82; snk_stall_pct = 0;
    run_random(150);

    set_config($urandom_range(4095), $urandom_range(900, 100), 1023, 1023, 1023,
               $urandom_range(15), 1);
    src_idle_pct = 0;  snk_stall_pct = 82;
    run_random(150);

    // Failure limit of zero locks at once; periods of zero.
    set_config(4095, 0, 0, 0, 0, $urandom_range(15), 0);
    src_idle_pct = 15; snk_stall_pct = 15;
    run_random(110);

    // Receiver holds off for a long stretch while ticks keep coming.
    set_config(0, 4095, $urandom_range(30, 1), $urandom_range(30, 1),
               $urandom_range(30, 1), $urandom_range(15), 3);
    src_idle_pct = 0;  snk_stall_pct = 0;
    run_random(80);
    hold_reqs <= hold_reqs + 1;
    run_random(80);

    set_config($urandom_range(4095), $urandom_range(1000), $urandom_range(1023, 1),
               $urandom_range(1023, 1), $urandom_range(1023, 1), $urandom_range(15), 7);
    src_idle_pct = 15; snk_stall_pct = 15;
    run_random(190);

    set_config($urandom_range(3000, 1000), $urandom_range(800, 300), $urandom_range(8, 1),
               $urandom_range(8, 1), $urandom_range(8, 1), 15, 7);
    src_idle_pct = 0;  snk_stall_pct = 82;
    run_random(170);

    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
